// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the serial link controller RTL.
// Clock clk_i and active-low reset rst_ni must be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GSLC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed: %m");

// Antecedent in one cycle implies consequent in the next.
`define GSLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ===== rtl/gslc_pkg.sv =====
// Types and constants shared by the serial link controller modules.
// No dependencies.
package gslc_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_RX     = 3'd1,
    CMD_POLL   = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_TOGGLE = 3'd4,
    CMD_TARGET = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    TX_NONE      = 3'd0,
    TX_STARTSTOP = 3'd1,
    TX_OPEN      = 3'd2,
    TX_CLOSE     = 3'd3,
    TX_QS        = 3'd4,
    TX_QX        = 3'd5
  } tx_code_e;

  typedef enum logic [1:0] {
    OP_IDLE    = 2'd0,
    OP_OPENING = 2'd1,
    OP_CLOSING = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MV_NONE  = 2'd0,
    MV_OPEN  = 2'd1,
    MV_CLOSE = 2'd2
  } move_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEND_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET       = 2'd3;

  localparam logic [15:0] ACK_WAIT_RST    = 16'd2000;
  localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;
  localparam logic [15:0] PEND_WINDOW_RST = 16'd3000;
  localparam logic [15:0] QUIET_RST       = 16'd1000;

  localparam logic [6:0] POS_FULL    = 7'd100;
  localparam logic [6:0] POS_RST     = 7'd50;
  localparam logic [7:0] EDGE_MARGIN = 8'd2;

  // Byte event towards the line parser.
  typedef struct packed {
    logic       byte_en;
    logic [7:0] data;
  } rx_ctl_t;

  // Completed line as seen by the control logic.
  typedef struct packed {
    logic       done;
    logic       ok;
    logic       kind_s;
    logic       kind_x;
    logic [7:0] value;
  } line_res_t;

  // One result transfer.
  typedef struct packed {
    tx_code_e   tx;
    op_e        op;
    logic [6:0] pos;
    logic       changed;
    logic       gave_up;
  } res_t;

endpackage

// ===== rtl/gate_serial_link_controller.sv =====
// Gate serial link controller: input register, control/parser logic, result register.
// Each item goes via the input and result registers; one transfer per cycle when not stalled.
// While a finished result waits in the output register the input register takes one more
// item, then stalls until that result transfers.
// Reset (rst_ni, async, active low) restores all config registers and state, empties the line.
// Depends on gslc_pkg, gslc_rx_parser, gslc_core and assert_macros.svh.
module gate_serial_link_controller #(
  parameter int unsigned LINE_DEPTH = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [gslc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gslc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      command_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic [6:0]                      target_percent_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gslc_pkg::tx_code_e              tx_code_o,
  output gslc_pkg::op_e                   operation_o,
  output logic [6:0]                      position_percent_o,
  output logic                            report_changed_o,
  output logic                            gave_up_o
);
  import gslc_pkg::*;
  `include "assert_macros.svh"

  // Input register stage
  logic       s1_valid_q;
  logic [2:0] s1_cmd_q;
  logic [7:0] s1_byte_q;
  logic [6:0] s1_tp_q;

  // Result register stage
  logic       out_valid_q;
  res_t       out_res_q;

  logic       out_ready, fire, in_xfer, flush;
  rx_ctl_t    rx_ctl;
  line_res_t  line_res;
  res_t       res;

  // The result register is free when empty or being taken this cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  // The held item is processed, and the state updated, as it moves to the result register.
  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign rx_ctl.byte_en = fire && (cmd_e'(s1_cmd_q) == CMD_RX);
  assign rx_ctl.data    = s1_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q  <= command_i;
      s1_byte_q <= rx_byte_i;
      s1_tp_q   <= target_percent_i;
    end
  end

  gslc_rx_parser #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_rx_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_ctl),
    .flush_i (flush),
    .line_o  (line_res)
  );

  gslc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .cmd_i       (s1_cmd_q),
    .target_i    (s1_tp_q),
    .line_i      (line_res),
    .flush_o     (flush),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tx_code_o          = out_res_q.tx;
  assign operation_o        = out_res_q.op;
  assign position_percent_o = out_res_q.pos;
  assign report_changed_o   = out_res_q.changed;
  assign gave_up_o          = out_res_q.gave_up;

  `GSLC_ASSERT(a_stall_needs_item, in_stall_o |-> s1_valid_q)
  `GSLC_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_o)
  `GSLC_ASSERT(a_giveup_no_move,
    (out_valid_o && gave_up_o) |-> (tx_code_o != TX_OPEN && tx_code_o != TX_CLOSE))

endmodule

// ===== rtl/gslc_rx_parser.sv =====
// Incremental receive line framer and hex reply parser.
// Depends on gslc_pkg and assert_macros.svh.
module gslc_rx_parser #(
  parameter int unsigned LINE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gslc_pkg::rx_ctl_t   rx_i,
  input  logic                flush_i,
  output gslc_pkg::line_res_t line_o
);
  import gslc_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned LenW = $clog2(LINE_DEPTH + 1);

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChXUp   = 8'h58;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_WS, PH_SIGN, PH_ZERO, PH_XPEND, PH_DIG, PH_END, PH_BAD
  } phase_e;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    if (c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61) begin
      d = c - 8'h57;
    end else begin
      d = c - 8'h37;
    end
    return d[3:0];
  endfunction

  logic [LenW-1:0] len_q, len_d;
  phase_e          phase_q, phase_d;
  logic            kind_s_q, kind_s_d, kind_x_q, kind_x_d;
  logic            neg_q, neg_d, any_q, any_d;
  logic [7:0]      val_q, val_d;

  logic            full;
  phase_e          ph_cur;
  logic            neg_cur, any_cur;
  logic [7:0]      val_cur, b;
  logic            past_hdr;

  assign b        = rx_i.data;
  assign full     = len_q >= LenW'(LINE_DEPTH);
  assign past_hdr = !(phase_q == PH_HDR0 || phase_q == PH_HDR1 || phase_q == PH_HDR2 ||
                      phase_q == PH_BAD);

  assign line_o.done   = rx_i.byte_en && (b == ChCr) && (len_q != '0);
  assign line_o.ok     = past_hdr && any_q;
  assign line_o.kind_s = kind_s_q;
  assign line_o.kind_x = kind_x_q;
  assign line_o.value  = neg_q ? (8'd0 - val_q) : val_q;

  // A full buffer restarts the line with the incoming byte as its first.
  assign ph_cur  = full ? PH_HDR0 : phase_q;
  assign neg_cur = full ? 1'b0 : neg_q;
  assign any_cur = full ? 1'b0 : any_q;
  assign val_cur = full ? 8'd0 : val_q;

  always_comb begin
    len_d    = len_q;
    phase_d  = phase_q;
    kind_s_d = kind_s_q;
    kind_x_d = kind_x_q;
    neg_d    = neg_q;
    any_d    = any_q;
    val_d    = val_q;
    priority if (flush_i || (rx_i.byte_en && b == ChCr)) begin
      len_d   = '0;
      phase_d = PH_HDR0;
      neg_d   = 1'b0;
      any_d   = 1'b0;
      val_d   = 8'd0;
    end else if (rx_i.byte_en && b != ChLf) begin
      len_d   = full ? LenW'(1) : len_q + LenW'(1);
      phase_d = ph_cur;
      neg_d   = neg_cur;
      any_d   = any_cur;
      val_d   = val_cur;
      unique case (ph_cur)
        PH_HDR0: phase_d = (b == ChQuery) ? PH_HDR1 : PH_BAD;
        PH_HDR1: begin
          kind_s_d = b == ChS;
          kind_x_d = b == ChX;
          phase_d  = PH_HDR2;
        end
        PH_HDR2: phase_d = (b == ChEq) ? PH_WS : PH_BAD;
        PH_WS, PH_SIGN: begin
          priority if (ph_cur == PH_WS &&
                       (b == ChSpace || b == ChTab || b == ChVt || b == ChFf)) begin
            phase_d = PH_WS;
          end else if (ph_cur == PH_WS && (b == ChPlus || b == ChMinus)) begin
            neg_d   = b == ChMinus;
            phase_d = PH_SIGN;
          end else if (is_hex(b)) begin
            any_d   = 1'b1;
            val_d   = {4'd0, hex_val(b)};
            phase_d = (b == ChZero) ? PH_ZERO : PH_DIG;
          end else begin
            phase_d = PH_END;
          end
        end
        PH_ZERO: begin
          priority if (b == ChX || b == ChXUp) begin
            phase_d = PH_XPEND;
          end else if (is_hex(b)) begin
            val_d   = {val_cur[3:0], hex_val(b)};
            phase_d = PH_DIG;
          end else begin
            phase_d = PH_END;
          end
        end
        PH_XPEND, PH_DIG: begin
          if (is_hex(b)) begin
            val_d   = {val_cur[3:0], hex_val(b)};
            phase_d = PH_DIG;
          end else begin
            phase_d = PH_END;
          end
        end
        PH_END, PH_BAD: phase_d = ph_cur;
        default: phase_d = PH_BAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      phase_q  <= PH_HDR0;
      kind_s_q <= 1'b0;
      kind_x_q <= 1'b0;
      neg_q    <= 1'b0;
      any_q    <= 1'b0;
      val_q    <= 8'd0;
    end else begin
      len_q    <= len_d;
      phase_q  <= phase_d;
      kind_s_q <= kind_s_d;
      kind_x_q <= kind_x_d;
      neg_q    <= neg_d;
      any_q    <= any_d;
      val_q    <= val_d;
    end
  end

  `GSLC_ASSERT(a_len_bound, len_q <= LenW'(LINE_DEPTH))
  `GSLC_ASSERT(a_hdr_len, past_hdr |-> len_q >= LenW'(3))

endmodule

// ===== rtl/gslc_core.sv =====
// Configuration registers and gate control state: replies, moves, retries, polls.
// Depends on gslc_pkg.
module gslc_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gslc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gslc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 fire_i,
  input  logic [2:0]                           cmd_i,
  input  logic [6:0]                           target_i,
  input  gslc_pkg::line_res_t                  line_i,
  output logic                                 flush_o,
  output gslc_pkg::res_t                       res_o
);
  import gslc_pkg::*;

  logic [15:0] ack_wait_q, pend_win_q, quiet_q;
  logic [7:0]  max_retries_q;

  op_e                   motion_q, motion_d;
  logic [6:0]            pos_q, pos_d, target_q, target_d;
  move_e                 pend_q, pend_d;
  logic [7:0]            retry_q, retry_d;
  logic [TIME_WIDTH-1:0] since_q, since_d, last_send_q, last_send_d, now_q, now_d;
  logic                  ask_s_q, ask_s_d;

  logic [TIME_WIDTH-1:0] el_pend, el_send;
  logic                  in_flight;

  assign el_pend   = now_q - since_q;
  assign el_send   = now_q - last_send_q;
  assign in_flight = (pend_q != MV_NONE) && (el_pend < TIME_WIDTH'(pend_win_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_wait_q    <= ACK_WAIT_RST;
      max_retries_q <= MAX_RETRIES_RST;
      pend_win_q    <= PEND_WINDOW_RST;
      quiet_q       <= QUIET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACK_WAIT:    ack_wait_q    <= cfg_data_i;
        CFG_MAX_RETRIES: max_retries_q <= cfg_data_i[7:0];
        CFG_PEND_WINDOW: pend_win_q    <= cfg_data_i;
        CFG_QUIET:       quiet_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    op_e        op;
    logic [6:0] np, tp;
    logic [8:0] vsum;
    move_e      mv;
    logic       resent, at_end;

    motion_d    = motion_q;
    pos_d       = pos_q;
    target_d    = target_q;
    pend_d      = pend_q;
    retry_d     = retry_q;
    since_d     = since_q;
    last_send_d = last_send_q;
    now_d       = now_q;
    ask_s_d     = ask_s_q;
    flush_o     = 1'b0;
    res_o.tx      = TX_NONE;
    res_o.changed = 1'b0;
    res_o.gave_up = 1'b0;
    op     = OP_IDLE;
    np     = 7'd0;
    tp     = 7'd0;
    vsum   = 9'd0;
    mv     = MV_NONE;
    resent = 1'b0;
    at_end = 1'b0;

    if (fire_i) begin
      unique case (cmd_e'(cmd_i))
        CMD_TICK: now_d = now_q + TIME_WIDTH'(1);
        CMD_RX: begin
          if (line_i.done && line_i.ok) begin
            if (line_i.kind_s) begin
              if (line_i.value[0]) begin
                op = line_i.value[1] ? OP_CLOSING : OP_OPENING;
              end
              if (op != motion_q) begin
                motion_d      = op;
                res_o.changed = 1'b1;
              end
              if ((pend_q == MV_OPEN && op == OP_OPENING) ||
                  (pend_q == MV_CLOSE && op == OP_CLOSING)) begin
                pend_d  = MV_NONE;
                retry_d = 8'd0;
              end
            end else if (line_i.kind_x) begin
              vsum = {1'b0, line_i.value} + {1'b0, EDGE_MARGIN};
              priority if (vsum >= {2'b00, POS_FULL}) begin
                np = POS_FULL;
              end else if (line_i.value <= EDGE_MARGIN) begin
                np = 7'd0;
              end else begin
                np = line_i.value[6:0];
              end
              if (np != pos_q) begin
                pos_d         = np;
                res_o.changed = 1'b1;
                // Partial target reached: stop (motion is non-idle here).
                if (motion_q != OP_IDLE && target_q != POS_FULL && target_q != 7'd0 &&
                    ((motion_q == OP_OPENING && np >= target_q) ||
                     (motion_q == OP_CLOSING && np <= target_q))) begin
                  res_o.tx    = TX_STARTSTOP;
                  last_send_d = now_q;
                  pend_d      = MV_NONE;
                end
              end
            end
          end
        end
        CMD_POLL: begin
          if (pend_q != MV_NONE && !(el_pend < TIME_WIDTH'(ack_wait_q))) begin
            at_end = (pend_q == MV_OPEN) ? (pos_q >= POS_FULL) : (pos_q == 7'd0);
            priority if (at_end) begin
              pend_d  = MV_NONE;
              retry_d = 8'd0;
            end else if (retry_q >= max_retries_q) begin
              pend_d        = MV_NONE;
              retry_d       = 8'd0;
              res_o.gave_up = 1'b1;
            end else begin
              retry_d     = retry_q + 8'd1;
              since_d     = now_q;
              last_send_d = now_q;
              res_o.tx    = (pend_q == MV_OPEN) ? TX_OPEN : TX_CLOSE;
              resent      = 1'b1;
            end
          end
          if (!resent && !(el_send < TIME_WIDTH'(quiet_q))) begin
            flush_o  = 1'b1;
            res_o.tx = ask_s_q ? TX_QS : TX_QX;
            ask_s_d  = !ask_s_q;
          end
        end
        CMD_STOP: begin
          if (motion_q != OP_IDLE || in_flight) begin
            res_o.tx    = TX_STARTSTOP;
            last_send_d = now_q;
            pend_d      = MV_NONE;
          end
        end
        CMD_TOGGLE: begin
          res_o.tx    = TX_STARTSTOP;
          last_send_d = now_q;
        end
        CMD_TARGET: begin
          tp       = (target_i > POS_FULL) ? POS_FULL : target_i;
          target_d = tp;
          priority if (tp == POS_FULL) begin
            mv = MV_OPEN;
          end else if (tp == 7'd0) begin
            mv = MV_CLOSE;
          end else if (tp > pos_q) begin
            mv = MV_OPEN;
          end else if (tp < pos_q) begin
            mv = MV_CLOSE;
          end else begin
            mv = MV_NONE;
          end
          if (mv != MV_NONE && !(mv == MV_OPEN && motion_q == OP_OPENING) &&
              !(mv == MV_CLOSE && motion_q == OP_CLOSING)) begin
            pend_d      = mv;
            since_d     = now_q;
            retry_d     = 8'd0;
            last_send_d = now_q;
            res_o.tx    = (mv == MV_OPEN) ? TX_OPEN : TX_CLOSE;
          end
        end
        default: ;
      endcase
    end

    res_o.op  = motion_d;
    res_o.pos = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q    <= OP_IDLE;
      pos_q       <= POS_RST;
      target_q    <= 7'd0;
      pend_q      <= MV_NONE;
      retry_q     <= 8'd0;
      since_q     <= '0;
      last_send_q <= '0;
      now_q       <= '0;
      ask_s_q     <= 1'b1;
    end else begin
      motion_q    <= motion_d;
      pos_q       <= pos_d;
      target_q    <= target_d;
      pend_q      <= pend_d;
      retry_q     <= retry_d;
      since_q     <= since_d;
      last_send_q <= last_send_d;
      now_q       <= now_d;
      ask_s_q     <= ask_s_d;
    end
  end

endmodule
